// ----- design/bsk_pkg.sv -----
`timescale 1ns / 1ps
package bsk_pkg;
  localparam int Clusters = 8;
  localparam int MaxSignatures = 1024;
  localparam int SigBits = 64;
  localparam int AddrW = $clog2(MaxSignatures);
  localparam int CntW = $clog2(MaxSignatures + 1);
  localparam int CluW = 4;
  localparam int DistW = 7;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SEED,
    ST_ASSIGN,
    ST_ASSIGN_END,
    ST_UPD_CLEAR,
    ST_UPD_SCAN,
    ST_UPD_WB,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic           load;     // write input signature
    logic           clr_set;  // clear count and overflow
    logic           seed;     // copy signature idx to centroid idx
    logic           asg_rd;   // issue read of signature idx for assign
    logic           tally_clr;
    logic           upd_rd;   // issue read of signature idx for update
    logic           upd_wb;   // write majority to centroid cidx
    logic           emit;     // present centroid cidx
    logic [AddrW:0] idx;
    logic [CluW-1:0] cidx;
    logic [CluW:0]  k;
    logic           first;
    logic           last_emit;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            changed;
    logic            busy_pipe;  // reads still in flight
  } stat_t;
endpackage

// ----- design/bsk_datapath.sv -----
`timescale 1ns / 1ps
module bsk_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bsk_pkg::ctrl_t               ctrl,
  input  logic [63:0]                  in_signature,
  output bsk_pkg::stat_t               stat,
  output logic [63:0]                  out_centroid,
  output logic [3:0]                   out_cluster_index,
  output logic                         out_final_centroid,
  output logic                         out_overflowed,
  output logic                         out_valid
);
  logic [63:0] sig_mem [bsk_pkg::MaxSignatures];
  logic [bsk_pkg::CluW-1:0] asg_mem [bsk_pkg::MaxSignatures];
  logic [63:0] cent_r [16];
  logic [bsk_pkg::CntW-1:0] count_r;
  logic ovf_r, changed_r;
  logic [bsk_pkg::CntW-1:0] tally_r [bsk_pkg::SigBits];
  logic [bsk_pkg::CntW-1:0] members_r;

  logic [63:0] rd_sig_r;
  logic [bsk_pkg::CluW-1:0] rd_asg_r;
  logic [bsk_pkg::AddrW-1:0] rd_addr_r, s2_addr_r;
  logic asg_v_r, upd_v_r, seed_v_r;
  logic [bsk_pkg::CluW-1:0] seed_c_r;

  // distance stage: one distance per centroid in parallel, registered
  logic [bsk_pkg::DistW-1:0] dist_r [bsk_pkg::Clusters];
  logic [bsk_pkg::CluW-1:0] old_asg_r;
  logic s2_v_r;

  logic [bsk_pkg::AddrW-1:0] ia;
  assign ia = ctrl.idx[bsk_pkg::AddrW-1:0];

  // memories: load write, single read port, assignment write
  logic asg_we;
  logic [bsk_pkg::CluW-1:0] best;
  always_ff @(posedge clk) begin
    if (ctrl.load && count_r < bsk_pkg::CntW'(bsk_pkg::MaxSignatures))
      sig_mem[count_r[bsk_pkg::AddrW-1:0]] <= in_signature;
    rd_sig_r <= sig_mem[ia];
    rd_asg_r <= asg_mem[ia];
    if (asg_we) asg_mem[s2_addr_r] <= best;
  end

  // read pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asg_v_r <= 1'b0; upd_v_r <= 1'b0; seed_v_r <= 1'b0; s2_v_r <= 1'b0;
    end else begin
      asg_v_r <= ctrl.asg_rd;
      upd_v_r <= ctrl.upd_rd;
      seed_v_r <= ctrl.seed;
      s2_v_r <= asg_v_r;
    end
    rd_addr_r <= ia;
    seed_c_r <= ctrl.idx[bsk_pkg::CluW-1:0];
    s2_addr_r <= rd_addr_r;
    old_asg_r <= rd_asg_r;
  end

  // popcount of xor per centroid
  always_ff @(posedge clk) begin
    for (int c = 0; c < bsk_pkg::Clusters; c++)
      dist_r[c] <= bsk_pkg::DistW'($countones(rd_sig_r ^ cent_r[c]));
  end

  // argmin over k, lower index wins ties
  always_comb begin
    logic [bsk_pkg::DistW-1:0] bd;
    bd = dist_r[0];
    best = '0;
    for (int c = 1; c < bsk_pkg::Clusters; c++) begin
      if (bsk_pkg::CluW'(c) < ctrl.k[bsk_pkg::CluW-1:0] || (ctrl.k[bsk_pkg::CluW] && c < 16))
        if (dist_r[c] < bd) begin
          bd = dist_r[c];
          best = bsk_pkg::CluW'(c);
        end
    end
  end
  assign asg_we = s2_v_r;

  // majority of current cluster
  logic [63:0] maj;
  logic [bsk_pkg::CntW-1:0] half;
  assign half = members_r >> 1;
  always_comb begin
    for (int b = 0; b < bsk_pkg::SigBits; b++) maj[b] = tally_r[b] > half;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; ovf_r <= 1'b0; changed_r <= 1'b0;
      for (int c = 0; c < 16; c++) cent_r[c] <= '0;
    end else begin
      if (ctrl.clr_set) begin
        count_r <= '0; ovf_r <= 1'b0;
      end else if (ctrl.load) begin
        if (count_r < bsk_pkg::CntW'(bsk_pkg::MaxSignatures)) count_r <= count_r + 1'b1;
        else ovf_r <= 1'b1;
      end
      if (seed_v_r) cent_r[seed_c_r] <= rd_sig_r;
      if (ctrl.upd_wb && members_r != '0) cent_r[ctrl.cidx] <= maj;
      if (ctrl.asg_rd && ctrl.idx == '0) changed_r <= ctrl.first;
      else if (s2_v_r && best != old_asg_r) changed_r <= 1'b1;
    end
  end

  // bit tally accumulation
  always_ff @(posedge clk) begin
    if (ctrl.tally_clr) begin
      members_r <= '0;
      for (int b = 0; b < bsk_pkg::SigBits; b++) tally_r[b] <= '0;
    end else if (upd_v_r && rd_asg_r == ctrl.cidx) begin
      members_r <= members_r + 1'b1;
      for (int b = 0; b < bsk_pkg::SigBits; b++)
        tally_r[b] <= tally_r[b] + bsk_pkg::CntW'(rd_sig_r[b]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= ctrl.emit;
    out_centroid <= cent_r[ctrl.cidx];
    out_cluster_index <= ctrl.cidx;
    out_final_centroid <= ctrl.last_emit;
    out_overflowed <= ovf_r;
  end

  assign stat.count = count_r;
  assign stat.changed = changed_r;
  assign stat.busy_pipe = asg_v_r | s2_v_r | upd_v_r | seed_v_r;
endmodule

// ----- design/bsk_ctrl.sv -----
`timescale 1ns / 1ps
module bsk_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_last_item,
  input  logic [7:0]     max_passes,
  input  bsk_pkg::stat_t stat,
  output bsk_pkg::ctrl_t ctrl,
  output logic           busy
);
  bsk_pkg::state_t state_r, state_nxt;
  logic [bsk_pkg::AddrW:0] idx_r, idx_nxt;
  logic [bsk_pkg::CluW-1:0] cidx_r, cidx_nxt;
  logic [bsk_pkg::CluW:0] k_r, k_nxt;
  logic [7:0] pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsk_pkg::ST_LOAD; idx_r <= '0; cidx_r <= '0; k_r <= '0; pass_r <= '0;
    end else begin
      state_r <= state_nxt; idx_r <= idx_nxt; cidx_r <= cidx_nxt;
      k_r <= k_nxt; pass_r <= pass_nxt;
    end
  end

  logic [bsk_pkg::CntW:0] cnt_ld;
  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; cidx_nxt = cidx_r; k_nxt = k_r; pass_nxt = pass_r;
    ctrl = '0;
    ctrl.idx = idx_r; ctrl.cidx = cidx_r; ctrl.k = k_r;
    ctrl.first = (pass_r == '0);
    busy = 1'b1;
    cnt_ld = '0;
    unique case (state_r)
      bsk_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (start) begin
          ctrl.load = 1'b1;
          if (in_last_item) begin
            cnt_ld = (bsk_pkg::CntW + 1)'(stat.count) +
              ((stat.count < bsk_pkg::CntW'(bsk_pkg::MaxSignatures)) ? 1'b1 : 1'b0);
            k_nxt = (cnt_ld < bsk_pkg::Clusters) ? (bsk_pkg::CluW + 1)'(cnt_ld)
                    : (bsk_pkg::CluW + 1)'(bsk_pkg::Clusters);
            idx_nxt = '0; pass_nxt = '0;
            state_nxt = bsk_pkg::ST_SEED;
          end
        end
      end
      bsk_pkg::ST_SEED: begin
        if (idx_r < (bsk_pkg::AddrW + 1)'(k_r)) begin
          ctrl.seed = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else if (!stat.busy_pipe) begin
          idx_nxt = '0;
          state_nxt = (max_passes == '0) ? bsk_pkg::ST_EMIT : bsk_pkg::ST_ASSIGN;
          cidx_nxt = '0;
        end
      end
      bsk_pkg::ST_ASSIGN: begin
        ctrl.asg_rd = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r + 1'b1 == (bsk_pkg::AddrW + 1)'(stat.count)) state_nxt = bsk_pkg::ST_ASSIGN_END;
      end
      bsk_pkg::ST_ASSIGN_END: begin
        if (!stat.busy_pipe) begin
          cidx_nxt = '0;
          if (stat.changed) state_nxt = bsk_pkg::ST_UPD_CLEAR;
          else state_nxt = bsk_pkg::ST_EMIT;
        end
      end
      bsk_pkg::ST_UPD_CLEAR: begin
        ctrl.tally_clr = 1'b1;
        idx_nxt = '0;
        state_nxt = bsk_pkg::ST_UPD_SCAN;
      end
      bsk_pkg::ST_UPD_SCAN: begin
        ctrl.upd_rd = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r + 1'b1 == (bsk_pkg::AddrW + 1)'(stat.count)) state_nxt = bsk_pkg::ST_UPD_WB;
      end
      bsk_pkg::ST_UPD_WB: begin
        if (!stat.busy_pipe) begin
          ctrl.upd_wb = 1'b1;
          idx_nxt = '0;
          if ((bsk_pkg::CluW + 1)'(cidx_r) + 1'b1 == k_r) begin
            cidx_nxt = '0;
            pass_nxt = pass_r + 1'b1;
            state_nxt = (pass_r + 1'b1 == max_passes) ? bsk_pkg::ST_EMIT
                        : bsk_pkg::ST_ASSIGN;
          end else begin
            cidx_nxt = cidx_r + 1'b1;
            state_nxt = bsk_pkg::ST_UPD_CLEAR;
          end
        end
      end
      bsk_pkg::ST_EMIT: begin
        ctrl.emit = 1'b1;
        ctrl.last_emit = ((bsk_pkg::CluW + 1)'(cidx_r) + 1'b1 == k_r);
        if (ctrl.last_emit) begin
          ctrl.clr_set = 1'b1;
          cidx_nxt = '0; pass_nxt = '0;
          state_nxt = bsk_pkg::ST_LOAD;
        end else cidx_nxt = cidx_r + 1'b1;
      end
      default: state_nxt = bsk_pkg::ST_LOAD;
    endcase
  end
endmodule

// ----- design/binary_signature_kmeans.sv -----
`timescale 1ns / 1ps
// Loading: one signature per cycle while busy is low.
// After the last item: seeding of k centroids from the first k signatures, then per
// pass an assignment scan and k update scans (one signature memory read a cycle).
// Then k results on consecutive cycles, registered; receiver cannot stall.
// Synchronous active-low reset: empty set, max_passes = 16, centroids zero.
module binary_signature_kmeans (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_signature,
  input  logic        in_last_item,
  output logic        out_valid,
  output logic [63:0] out_centroid,
  output logic [3:0]  out_cluster_index,
  output logic        out_final_centroid,
  output logic        out_overflowed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_max_passes
);
  bsk_pkg::ctrl_t ctrl;
  bsk_pkg::stat_t stat;
  logic [7:0] max_passes_r;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) max_passes_r <= 8'd16;
    else if (cfg_valid && cfg_ready) max_passes_r <= cfg_max_passes;
  end

  bsk_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_last_item, .max_passes(max_passes_r),
    .stat, .ctrl, .busy
  );

  bsk_datapath u_dp (
    .clk, .rst_n, .ctrl, .in_signature, .stat,
    .out_centroid, .out_cluster_index, .out_final_centroid, .out_overflowed, .out_valid
  );
endmodule

// ----- design/bsk_checker.sv -----
`timescale 1ns / 1ps
module bsk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_last_item,
  input logic       out_valid,
  input logic [3:0] out_cluster_index,
  input logic       out_final_centroid
);
  a_idx0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> out_cluster_index == 4'd0)
    else $error("first centroid not index 0");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) |-> out_cluster_index == $past(out_cluster_index) + 4'd1)
    else $error("cluster index skipped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_item |=> busy)
    else $error("not busy after last item");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_centroid |=> out_valid)
    else $error("results broken off");
endmodule

bind binary_signature_kmeans bsk_checker u_chk (
  .clk, .rst_n, .start, .busy, .in_last_item, .out_valid,
  .out_cluster_index, .out_final_centroid
);
